// ===== rtl/core/eprs_pkg.sv =====
// Shared types, constants and microcode ROM of the exact power root solver.
`default_nettype none

package eprs_pkg;

    localparam int VALUE_BITS_DEF = 63;
    localparam int ACC_W          = 63;
    localparam int CAND_W         = 32;
    localparam int PROD_W         = 2 * CAND_W;
    localparam int SUM_W          = ACC_W + CAND_W + 1;
    localparam int BIT_W          = 5;
    localparam int CNT_W          = 6;
    localparam int UPC_W          = 5;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [1:0] {
        STS_SOLVED     = 2'd0,
        STS_BAD_TWOPOW = 2'd1,
        STS_NO_ROOT    = 2'd2,
        STS_ROOT_SMALL = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_REM,
        OP_ROOT_REM,
        OP_TRIAL,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACC,
        OP_NEXT_BIT,
        OP_KEEP,
        OP_VINIT,
        OP_SET_S0,
        OP_SET_S1,
        OP_SET_S2,
        OP_SET_S3,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_TWOM_BAD,
        C_N_ZERO,
        C_N_ONE,
        C_CNT_ZERO,
        C_NOT_OVER,
        C_VERIFY,
        C_BIT_ZERO,
        C_ACC_NE_REM,
        C_ROOT_LT2,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  tgt;
    } ctrl_word_t;

    // Microcode step addresses
    localparam upc_t U_IDLE    = 5'd0;
    localparam upc_t U_REM     = 5'd1;
    localparam upc_t U_DEG     = 5'd2;
    localparam upc_t U_DEG1    = 5'd3;
    localparam upc_t U_TRIAL   = 5'd4;
    localparam upc_t U_MLO     = 5'd5;
    localparam upc_t U_MHI     = 5'd6;
    localparam upc_t U_ACC     = 5'd7;
    localparam upc_t U_TFAIL   = 5'd8;
    localparam upc_t U_BITCHK  = 5'd9;
    localparam upc_t U_NEXT    = 5'd10;
    localparam upc_t U_TPASS   = 5'd11;
    localparam upc_t U_TBACK   = 5'd12;
    localparam upc_t U_VSTART  = 5'd13;
    localparam upc_t U_VCHK    = 5'd14;
    localparam upc_t U_FIN     = 5'd15;
    localparam upc_t U_SOLVED  = 5'd16;
    localparam upc_t U_F1      = 5'd17;
    localparam upc_t U_F2      = 5'd18;
    localparam upc_t U_F3      = 5'd19;
    localparam upc_t U_EMIT    = 5'd20;
    localparam upc_t U_EWAIT   = 5'd21;

    // Jump to tgt when cond holds, else fall through to the next step.
    function automatic ctrl_word_t ucode_rom(input upc_t addr);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, tgt: U_IDLE};
        case (addr)
            U_IDLE:   w = '{op: OP_LOAD,     cond: C_NO_ACCEPT,  tgt: U_IDLE};
            U_REM:    w = '{op: OP_REM,      cond: C_TWOM_BAD,   tgt: U_F1};
            U_DEG:    w = '{op: OP_NOP,      cond: C_N_ZERO,     tgt: U_F2};
            U_DEG1:   w = '{op: OP_ROOT_REM, cond: C_N_ONE,      tgt: U_FIN};
            U_TRIAL:  w = '{op: OP_TRIAL,    cond: C_NEVER,      tgt: U_IDLE};
            U_MLO:    w = '{op: OP_MUL_LO,   cond: C_CNT_ZERO,   tgt: U_TPASS};
            U_MHI:    w = '{op: OP_MUL_HI,   cond: C_NEVER,      tgt: U_IDLE};
            U_ACC:    w = '{op: OP_ACC,      cond: C_NOT_OVER,   tgt: U_MLO};
            U_TFAIL:  w = '{op: OP_NOP,      cond: C_VERIFY,     tgt: U_F2};
            U_BITCHK: w = '{op: OP_NOP,      cond: C_BIT_ZERO,   tgt: U_VSTART};
            U_NEXT:   w = '{op: OP_NEXT_BIT, cond: C_ALWAYS,     tgt: U_TRIAL};
            U_TPASS:  w = '{op: OP_KEEP,     cond: C_VERIFY,     tgt: U_VCHK};
            U_TBACK:  w = '{op: OP_NOP,      cond: C_ALWAYS,     tgt: U_BITCHK};
            U_VSTART: w = '{op: OP_VINIT,    cond: C_ALWAYS,     tgt: U_MLO};
            U_VCHK:   w = '{op: OP_NOP,      cond: C_ACC_NE_REM, tgt: U_F2};
            U_FIN:    w = '{op: OP_NOP,      cond: C_ROOT_LT2,   tgt: U_F3};
            U_SOLVED: w = '{op: OP_SET_S0,   cond: C_ALWAYS,     tgt: U_EMIT};
            U_F1:     w = '{op: OP_SET_S1,   cond: C_ALWAYS,     tgt: U_EMIT};
            U_F2:     w = '{op: OP_SET_S2,   cond: C_ALWAYS,     tgt: U_EMIT};
            U_F3:     w = '{op: OP_SET_S3,   cond: C_NEVER,      tgt: U_IDLE};
            U_EMIT:   w = '{op: OP_EMIT,     cond: C_OUT_FREE,   tgt: U_IDLE};
            U_EWAIT:  w = '{op: OP_NOP,      cond: C_ALWAYS,     tgt: U_EMIT};
            default:  w = '{op: OP_NOP,      cond: C_ALWAYS,     tgt: U_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/exact_power_root_solver_core.sv =====
// Top level of the exact power root solver: microcode sequencer and datapath.
//
// Usage: each input item (p, m, n) on s_* is solved for p = 2^m + q^n. One
// result item (m_root_value, m_status) comes out on m_* for every input item,
// in order. Status 0 means solved and carries q; 1 means 2^m does not fit or
// is not below p; 2 means no exact n-th root or n is zero; 3 means the root
// is below two. On any nonzero status the root is zero.
// A rejected 2^m, degree zero and degree one skip the root search. For n >= 2
// the root is built over 32 candidate bits; each multiply runs a low and a
// high 32x32 partial product and a 96-bit add/compare on one shared
// multiplier, each candidate adds sequencing steps, and a candidate stops
// early on overflow.
// One item is worked on at a time: s_ready is high only in the idle step, so a
// new item can be accepted from the cycle after the previous result is issued.
// The result sits in an output register: a stalled receiver holds it there,
// and the next item is accepted while it waits; the sequencer only stops at
// its emit step if the previous result has not yet been taken.
// Reset (aresetn low at a clock edge) returns the sequencer to idle and
// drops any pending result.
`default_nettype none

module exact_power_root_solver_core
    import eprs_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  wire  [ACC_W-1:0] s_target_value,
    input  wire  [5:0]       s_two_exponent,
    input  wire  [5:0]       s_root_degree,
    output logic             m_valid,
    input  wire              m_ready,
    output logic [ACC_W-1:0] m_root_value,
    output logic [1:0]       m_status
);

    // Sequencer
    upc_t       upc_reg, upc_next;
    ctrl_word_t cw;

    // Datapath registers
    logic [VALUE_BITS-1:0] p_reg, p_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [5:0]            m_reg, m_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [BIT_W-1:0]      bit_reg, bit_next;
    logic [CAND_W-1:0]     cand_reg, cand_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [ACC_W-1:0]      res_reg, res_next;
    logic [PROD_W-1:0]     plo_reg, plo_next;
    logic [ACC_W-1:0]      phi_reg, phi_next;
    logic                  verify_reg, verify_next;
    status_t               sts_reg, sts_next;

    // Output register
    logic             m_valid_reg, m_valid_next;
    logic [ACC_W-1:0] m_root_reg, m_root_next;
    status_t          m_status_reg, m_status_next;

    // Combinational datapath
    logic [VALUE_BITS-1:0] two_m;
    logic                  twom_bad;
    logic [CAND_W-1:0]     mul_a;
    logic [PROD_W-1:0]     prod;
    logic [SUM_W-1:0]      sum;
    logic                  over;
    logic                  out_free;
    logic                  cond_hit;

    assign cw = ucode_rom(upc_reg);

    assign two_m    = {{(VALUE_BITS-1){1'b0}}, 1'b1} << m_reg;
    assign twom_bad = (int'(m_reg) >= VALUE_BITS) || (two_m >= p_reg);

    // Shared 32x32 multiplier: low or high half of the accumulator times cand.
    assign mul_a = (cw.op == OP_MUL_HI) ? CAND_W'(acc_reg[ACC_W-1:CAND_W])
                                        : acc_reg[CAND_W-1:0];
    assign prod  = PROD_W'(mul_a) * PROD_W'(cand_reg);

    // Recombine the partial products and test against the remainder.
    assign sum  = {1'b0, phi_reg, {CAND_W{1'b0}}} + {{(SUM_W-PROD_W){1'b0}}, plo_reg};
    assign over = sum > SUM_W'(rem_reg);

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (cw.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_ALWAYS:     cond_hit = 1'b1;
            C_NO_ACCEPT:  cond_hit = !s_valid;
            C_TWOM_BAD:   cond_hit = twom_bad;
            C_N_ZERO:     cond_hit = (n_reg == '0);
            C_N_ONE:      cond_hit = (n_reg == CNT_W'(1));
            C_CNT_ZERO:   cond_hit = (cnt_reg == '0);
            C_NOT_OVER:   cond_hit = !over;
            C_VERIFY:     cond_hit = verify_reg;
            C_BIT_ZERO:   cond_hit = (bit_reg == '0);
            C_ACC_NE_REM: cond_hit = (acc_reg != ACC_W'(rem_reg));
            C_ROOT_LT2:   cond_hit = (res_reg < ACC_W'(2));
            C_OUT_FREE:   cond_hit = out_free;
            default:      cond_hit = 1'b0;
        endcase
    end

    assign upc_next = cond_hit ? cw.tgt : upc_reg + UPC_W'(1);
    assign s_ready  = (cw.op == OP_LOAD);

    // Next values of the datapath, one micro-operation per step
    always_comb begin
        p_next        = p_reg;
        rem_next      = rem_reg;
        m_next        = m_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        bit_next      = bit_reg;
        cand_next     = cand_reg;
        acc_next      = acc_reg;
        res_next      = res_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        verify_next   = verify_reg;
        sts_next      = sts_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_root_next   = m_root_reg;
        m_status_next = m_status_reg;
        case (cw.op)
            OP_LOAD: begin
                p_next = s_target_value[VALUE_BITS-1:0];
                m_next = s_two_exponent;
                n_next = s_root_degree;
            end
            OP_REM: begin
                rem_next = p_reg - two_m;
            end
            OP_ROOT_REM: begin
                // degree one: root is the remainder; else clear for the search
                res_next    = (n_reg == CNT_W'(1)) ? ACC_W'(rem_reg) : '0;
                bit_next    = '1;
                verify_next = 1'b0;
            end
            OP_TRIAL: begin
                cand_next = res_reg[CAND_W-1:0] | (CAND_W'(1) << bit_reg);
                acc_next  = ACC_W'(1);
                cnt_next  = n_reg;
            end
            OP_MUL_LO: begin
                plo_next = prod;
            end
            OP_MUL_HI: begin
                phi_next = prod[ACC_W-1:0];
            end
            OP_ACC: begin
                acc_next = sum[ACC_W-1:0];
                cnt_next = cnt_reg - CNT_W'(1);
            end
            OP_NEXT_BIT: begin
                bit_next = bit_reg - BIT_W'(1);
            end
            OP_KEEP: begin
                if (!verify_reg) begin
                    res_next = ACC_W'(cand_reg);
                end
            end
            OP_VINIT: begin
                verify_next = 1'b1;
                cand_next   = res_reg[CAND_W-1:0];
                acc_next    = ACC_W'(1);
                cnt_next    = n_reg;
            end
            OP_SET_S0: sts_next = STS_SOLVED;
            OP_SET_S1: sts_next = STS_BAD_TWOPOW;
            OP_SET_S2: sts_next = STS_NO_ROOT;
            OP_SET_S3: sts_next = STS_ROOT_SMALL;
            OP_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_root_next   = (sts_reg == STS_SOLVED) ? res_reg : '0;
                    m_status_next = sts_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= U_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg     <= upc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        p_reg        <= p_next;
        rem_reg      <= rem_next;
        m_reg        <= m_next;
        n_reg        <= n_next;
        cnt_reg      <= cnt_next;
        bit_reg      <= bit_next;
        cand_reg     <= cand_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        verify_reg   <= verify_next;
        sts_reg      <= sts_next;
        m_root_reg   <= m_root_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_root_value = m_root_reg;
    assign m_status     = m_status_reg;

`ifndef NO_ASSERTIONS
    // A new result only appears out of the emit step.
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(upc_reg == U_EMIT))
        else $error("result appeared outside the emit step");

    // An accepted item always starts the remainder step next.
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (upc_reg == U_REM))
        else $error("accepted item did not start the sequence");

    // A solved result carries a root of at least two; others carry zero.
    a_root_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_status == STS_SOLVED) ? (m_root_value >= ACC_W'(2))
                                              : (m_root_value == '0)))
        else $error("root field inconsistent with status");

    // The running power never exceeds the remainder at a multiply step.
    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == U_MLO) |-> (acc_reg <= ACC_W'(rem_reg)))
        else $error("running power exceeded the remainder");
`endif

endmodule

`default_nettype wire

// ===== tb/exact_power_root_solver_core_test.sv =====
// Self-checking testbench for the exact power root solver core.
`timescale 1ns / 1ps

module exact_power_root_solver_core_test;
    import eprs_pkg::*;

    // One input item: p, m and n of p = 2^m + q^n.
    typedef struct packed {
        logic [ACC_W-1:0] target;
        logic [5:0]       two_exp;
        logic [5:0]       degree;
    } split_item_t;

    // One result item: the root q and why it was or was not found.
    typedef struct packed {
        logic [ACC_W-1:0] root;
        status_t          status;
    } split_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [ACC_W-1:0] s_target_value = '0;
    logic [5:0]       s_two_exponent = '0;
    logic [5:0]       s_root_degree = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [ACC_W-1:0] m_root_value;
    logic [1:0]       m_status;

    split_item_t   pending_items[$];
    split_item_t   current_item = '0;
    split_result_t expected_splits[$];

    int send_gap = 0;
    int recv_gap = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;
    int items_sent = 0;
    int results_seen = 0;
    int fail_count = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    exact_power_root_solver_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_target_value (s_target_value),
        .s_two_exponent (s_two_exponent),
        .s_root_degree  (s_root_degree),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_root_value   (m_root_value),
        .m_status       (m_status)
    );

    always #6 aclk = ~aclk;

    // True when base^deg stays within ceiling; prod then holds base^deg.
    // The division guard keeps every partial product inside 64 bits.
    function automatic bit power_fits(input longint unsigned base, input int unsigned deg,
                                      input longint unsigned ceiling,
                                      output longint unsigned prod);
        longint unsigned acc;
        int unsigned     i;
        acc  = 1;
        prod = 0;
        for (i = 0; i < deg; i++) begin
            if (acc > ceiling / base)
                return 1'b0;
            acc = acc * base;
        end
        prod = acc;
        return 1'b1;
    endfunction

    // Solve p = 2^m + q^n for q, exactly as the block should.
    function automatic split_result_t solve_power_split(input split_item_t it);
        split_result_t   res;
        longint unsigned p;
        longint unsigned two_m;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned cand;
        longint unsigned prod;
        int unsigned     deg;
        int              b;
        res.root   = '0;
        res.status = STS_SOLVED;
        p          = {1'b0, it.target};
        deg        = it.degree;

        // The power of two must fit the value width and stay below p.
        if (it.two_exp >= VALUE_BITS_DEF) begin
            res.status = STS_BAD_TWOPOW;
            return res;
        end
        two_m = 64'd1 << it.two_exp;
        if (two_m >= p) begin
            res.status = STS_BAD_TWOPOW;
            return res;
        end
        rem = p - two_m;

        if (deg == 0) begin
            res.status = STS_NO_ROOT;
            return res;
        end
        if (deg == 1) begin
            root = rem;
        end else begin
            // Build the floor root one bit at a time, then demand exactness.
            root = 0;
            for (b = 31; b >= 0; b--) begin
                cand = root | (64'd1 << b);
                if (power_fits(cand, deg, rem, prod))
                    root = cand;
            end
            if (root == 0 || !power_fits(root, deg, rem, prod) || prod != rem) begin
                res.status = STS_NO_ROOT;
                return res;
            end
        end

        if (root < 2)
            res.status = STS_ROOT_SMALL;
        else
            res.root = root[ACC_W-1:0];
        return res;
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic add_item(input longint unsigned target, input int two_exp,
                            input int degree);
        split_item_t it;
        it.target  = target[ACC_W-1:0];
        it.two_exp = two_exp[5:0];
        it.degree  = degree[5:0];
        pending_items = {pending_items, it};
    endtask

    // Build p = 2^m + q^n from a random q and n, so that most items get past
    // the early rejections and exercise the full root search. About one in
    // six is knocked off by one to land just beside a perfect power.
    task automatic add_power_sum_item();
        int              pick;
        int              deg;
        int              qbits;
        int              w;
        int              m;
        int              i;
        longint unsigned q;
        longint unsigned qn;
        longint unsigned p;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            deg = $urandom_range(2, 4);
        else if (pick < 7)
            deg = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(5, 8);
        else if (pick < 9)
            deg = $urandom_range(9, 20);
        else
            deg = $urandom_range(21, 62);
        qbits = 62 / deg;
        w     = $urandom_range(1, qbits);
        q     = {$urandom, $urandom} & ((64'd1 << w) - 1);
        qn    = 1;
        for (i = 0; i < deg; i++)
            qn = qn * q;
        m = $urandom_range(0, 61);
        p = (64'd1 << m) + qn;
        if ($urandom_range(0, 5) == 0)
            p = $urandom_range(0, 1) ? p + 1 : p - 1;
        add_item(p, m, deg);
    endtask

    // Driver: present queued items on s_*, holding each until accepted and
    // idling a drawn number of cycles between items. Predict each result at
    // the accepting edge.
    always @(posedge aclk) begin : drive_items
        logic next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                expected_splits = {expected_splits, solve_power_split(current_item)};
                items_sent++;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_gap   = draw_wait(send_burst);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    current_item = pending_items.pop_front();
                    s_target_value <= current_item.target;
                    s_two_exponent <= current_item.two_exp;
                    s_root_degree  <= current_item.degree;
                    next_valid = 1'b1;
                end
            end
            s_valid <= next_valid;
        end
    end

    // Monitor: check each result item against the oldest prediction, then
    // stall m_ready for a drawn number of cycles.
    always @(posedge aclk) begin : check_results
        split_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_splits.size() == 0) begin
                    $error("result item with nothing pending: root_value=%0d status=%0d",
                           m_root_value, m_status);
                    fail_count++;
                end else begin
                    want = expected_splits.pop_front();
                    status_seen[want.status]++;
                    if (m_root_value !== want.root) begin
                        $error("root_value mismatch: expected %0d, actual %0d",
                               want.root, m_root_value);
                        fail_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_status);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                recv_gap = draw_wait(recv_burst);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : run_test
        longint unsigned max_p;
        longint unsigned big_q;
        int              k;
        max_p = (64'd1 << 63) - 1;
        big_q = 64'd3037000499;  // largest q with q^2 below 2^63

        // Directed items: field extremes and each corner of the solver.
        add_item(0, 0, 2);                             // p zero: two-power not below p
        add_item(1, 0, 2);                             // 2^0 equals p
        add_item(64'd1 << 62, 62, 2);                  // 2^m equals p at top exponent
        add_item(max_p, 63, 1);                        // 2^m overflows the value width
        add_item(max_p, 62, 1);                        // degree one, remainder below 2^62
        add_item(max_p, 0, 1);                         // degree one, all-ones-ish root
        add_item(10, 1, 0);                            // degree zero
        add_item(max_p, 0, 0);                         // degree zero at max p
        add_item(2, 0, 1);                             // degree one, remainder one
        add_item(9, 2, 1);                             // degree one, solved
        add_item(3, 0, 5);                             // remainder two, no fifth root
        add_item(2, 0, 63);                            // remainder one at max degree
        add_item(2, 0, 2);                             // remainder one, degree two
        add_item((64'd1 << 62) + 1, 0, 62);            // q = 2 at degree 62
        add_item(big_q * big_q + (64'd1 << 32), 32, 2); // largest square root
        add_item(big_q * big_q + (64'd1 << 32) + 1, 32, 2);
        add_item((64'd1 << 62) + 2, 0, 2);             // just past a perfect square
        add_item(347, 2, 3);                           // 4 + 7^3
        add_item(64'd4052555153018976267 + 1, 0, 39);  // 1 + 3^39
        add_item(max_p, 0, 63);                        // max p, max degree
        add_item(max_p, 0, 2);                         // max p, not a square
        add_item(max_p, 63, 63);                       // every input bit high

        // Random items: mostly well-formed power sums, the rest raw noise.
        for (k = 0; k < 530; k++) begin
            if ($urandom_range(0, 6) == 0)
                add_item({$urandom, $urandom}, $urandom_range(0, 63), $urandom_range(0, 63));
            else
                add_power_sum_item();
        end

        // Hold reset low, then release it once.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: all items accepted, all predictions checked, then a margin.
        while (pending_items.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_splits.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("Sent %0d items and checked %0d results under random idling on both sides.",
                 items_sent, results_seen);
        $display("Outcomes: %0d solved, %0d two-power rejects, %0d without exact root, %0d small roots.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0)
            $display("exact_power_root_solver_core_test: PASS");
        else
            $display("exact_power_root_solver_core_test: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of every item.
    initial begin : watchdog
        #200_000_000;
        $display("exact_power_root_solver_core_test: FAIL");
        $finish;
    end

endmodule
